>>> rtl/vertex_weld_dedup_table_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef VERTEX_WELD_DEDUP_TABLE_UNIT_DEFINES_SVH
`define VERTEX_WELD_DEDUP_TABLE_UNIT_DEFINES_SVH

// Implication checked on every edge outside reset.
`define VWD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define VWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/vwd_pkg.sv
// ----------------------------------------------------------------------------
// vwd_pkg
// Types, sizes and the IEEE compare shared by the vertex weld table.
// ----------------------------------------------------------------------------
package vwd_pkg;

  localparam int TableDepth = 256;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int OutIdxW    = 8;
  localparam int Comps      = 8;

  typedef struct packed {
    logic        start_of_mesh;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] nrm_x;
    logic [31:0] nrm_y;
    logic [31:0] nrm_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic [OutIdxW-1:0] vertex_index;
    logic               was_inserted;
    logic               table_overflow;
  } out_item_t;

  typedef logic [Comps*32-1:0] corner_t;

  function automatic logic is_nan(input logic [31:0] a);
    is_nan = (a[30:0] > 31'h7F800000);
  endfunction

  function automatic logic ieee_eq(input logic [31:0] a, input logic [31:0] b);
    logic zero_pair;
    zero_pair = ((a[30:0] | b[30:0]) == 31'd0);
    ieee_eq = !is_nan(a) && !is_nan(b) && (zero_pair || (a == b));
  endfunction

endpackage

>>> rtl/vwd_cell.sv
// ----------------------------------------------------------------------------
// vwd_cell
// One table slot: holds an entry and compares it with the broadcast corner.
// ----------------------------------------------------------------------------
module vwd_cell (
  input  logic                 clk,
  input  logic [vwd_pkg::IdxW-1:0] cell_idx,
  input  logic [vwd_pkg::CntW-1:0] count,
  input  vwd_pkg::corner_t     corner,
  input  logic                 cmp_en,
  input  logic                 wr_en,
  input  logic [vwd_pkg::IdxW-1:0] wr_idx,
  output logic                 match_r
);
  import vwd_pkg::*;

  corner_t entry_r;
  logic    all_eq;
  logic    match_nxt;

  always_comb begin
    all_eq = 1'b1;
    for (int k = 0; k < Comps; k++) begin
      all_eq = all_eq & ieee_eq(entry_r[k*32 +: 32], corner[k*32 +: 32]);
    end
    // slot only counts once written in this mesh
    match_nxt = all_eq && ({1'b0, cell_idx} < count);
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == cell_idx)) begin
      entry_r <= corner;
    end
    if (cmp_en) begin
      match_r <= match_nxt;
    end
  end

endmodule

>>> rtl/vertex_weld_dedup_table_unit.sv
// Each accepted item passes through the compare and resolve states before
// its result is registered; a new item is taken only when idle, so the row
// of cells compares one corner per pass and the append is done in the resolve
// cycle. A stalled result holds off the next item until it is taken.
// Reset: rst_n (synchronous, active low) clears the control FSM, the entry
// count and the output valid; stored entries are not cleared.
// ----------------------------------------------------------------------------
// vertex_weld_dedup_table_unit
// Welds mesh corners into a table of unique vertices held in a row of cells.
// ----------------------------------------------------------------------------
module vertex_weld_dedup_table_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vwd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vwd_pkg::out_item_t out_data
);
  import vwd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RES  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  corner_t         corner_r;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic            in_acc;
  logic            wr_en;
  logic [TableDepth-1:0] match;
  logic            found;
  logic [IdxW-1:0] hit_idx;

  // Take a new item only when idle and the output slot is free or draining.
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // Row of cells; each compares the broadcast corner in the compare cycle.
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    vwd_cell u_cell (
      .clk      (clk),
      .cell_idx (IdxW'(g)),
      .count    (count_r),
      .corner   (corner_r),
      .cmp_en   (state_r == S_CMP),
      .wr_en    (wr_en),
      .wr_idx   (count_r[IdxW-1:0]),
      .match_r  (match[g])
    );
  end

  // At most one cell matches, so an OR of masked indexes gives the hit.
  always_comb begin
    found   = |match;
    hit_idx = '0;
    for (int i = 0; i < TableDepth; i++) begin
      hit_idx = hit_idx | (match[i] ? IdxW'(i) : '0);
    end
  end

  assign wr_en = (state_r == S_RES) && !found && (count_r < CntW'(TableDepth));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CMP;
          if (in_data.start_of_mesh) begin
            count_nxt = '0;
          end
        end
      end
      S_CMP: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (found) begin
          out_data_nxt = '{vertex_index: OutIdxW'(hit_idx), was_inserted: 1'b0,
                           table_overflow: 1'b0};
        end else if (wr_en) begin
          out_data_nxt = '{vertex_index: OutIdxW'(count_r), was_inserted: 1'b1,
                           table_overflow: 1'b0};
          count_nxt    = count_r + CntW'(1);
        end else begin
          out_data_nxt = '{vertex_index: '0, was_inserted: 1'b0,
                           table_overflow: 1'b1};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      corner_r <= {in_data.tex_v, in_data.tex_u, in_data.nrm_z, in_data.nrm_y,
                   in_data.nrm_x, in_data.pos_z, in_data.pos_y, in_data.pos_x};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/vwd_checker.sv
// ----------------------------------------------------------------------------
// vwd_checker
// Port-level checks for the vertex weld table, bound to the top level.
// ----------------------------------------------------------------------------
`include "vertex_weld_dedup_table_unit_defines.svh"

module vwd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input vwd_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input vwd_pkg::out_item_t out_data
);
  import vwd_pkg::*;

  `VWD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `VWD_ASSERT_IMP(a_ovf_idx, out_valid && out_data.table_overflow, out_data.vertex_index == '0 && !out_data.was_inserted, "overflow result not clean")
  `VWD_ASSERT_NEXT(a_acc_gap, in_valid && !in_stall, !out_valid, "result overlaps new item")
  `VWD_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "second item taken too early")

endmodule

bind vertex_weld_dedup_table_unit vwd_checker u_vwd_checker (.*);
